>>> sv/cmm_pkg.sv
// Shared constants, types and codes for the channel matrix mixer.
package cmm_pkg;

    // Default build parameters
    localparam int MAX_CHANNELS_DEF   = 8;
    localparam int GAIN_FRAC_BITS_DEF = 14;
    localparam int QUEUE_DEPTH        = 4;

    // Output channel count never exceeds this, whatever the matrix size
    localparam int OUT_CHANNELS_CAP = 8;

    // Field widths
    localparam int CFG_W      = 4;
    localparam int CFG_ADDR_W = 1;
    localparam int CH_W       = 3;
    localparam int COEF_W     = 18;
    localparam int SAMPLE_W   = 16;
    localparam int CNT_W      = 4;
    localparam int PROD_W     = COEF_W + SAMPLE_W;

    // Input tdata layout
    localparam int ROW_LSB    = 0;
    localparam int COL_LSB    = ROW_LSB + CH_W;
    localparam int COEF_LSB   = COL_LSB + CH_W;
    localparam int SAMPLE_LSB = COEF_LSB + COEF_W;
    localparam int S_TDATA_W  = 40;

    // Output tdata layout
    localparam int MIX_LSB    = 0;
    localparam int CH_LSB     = MIX_LSB + SAMPLE_W;
    localparam int M_TDATA_W  = 24;

    // Channel count registers reset to stereo
    localparam logic [CFG_W-1:0] CH_COUNT_RESET = CFG_W'(2);

    // Output saturation limits
    localparam logic signed [SAMPLE_W-1:0] CLIP_LOW  = 16'sh8000;
    localparam logic signed [SAMPLE_W-1:0] CLIP_HIGH = 16'sh7fff;

    typedef enum logic {
        OP_COEF   = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_INPUT_CHANNELS  = 1'b0,
        REG_OUTPUT_CHANNELS = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        BK_IDLE  = 1'b0,
        BK_ISSUE = 1'b1
    } back_state_t;

    // One classified item, front to back
    typedef struct packed {
        op_t                        kind;
        logic                       gain_ok;
        logic [CH_W-1:0]            row;
        logic [CH_W-1:0]            col;
        logic signed [COEF_W-1:0]   coefficient;
        logic                       store_en;
        logic [CNT_W-1:0]           store_idx;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       mix;
        logic [CNT_W-1:0]           n_in;
        logic [CNT_W-1:0]           n_out;
    } cmm_entry_t;

endpackage

>>> sv/cmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cmm_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 64
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> sv/cmm_front.sv
// Front end: channel count registers, input decode and frame counting.
module cmm_front #(
    parameter int MAX_CHANNELS = cmm_pkg::MAX_CHANNELS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [cmm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [cmm_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [cmm_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tuser,
    output logic                           q_push,
    output cmm_pkg::cmm_entry_t            q_entry,
    input  logic                           q_full
);
    import cmm_pkg::*;

    localparam int OUT_LIMIT =
        (MAX_CHANNELS < OUT_CHANNELS_CAP) ? MAX_CHANNELS : OUT_CHANNELS_CAP;

    logic [CFG_W-1:0] in_ch_reg, out_ch_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] n_in, n_out, cnt_inc;
    logic             accept, is_sample, frame_done;

    // Saturate counts into their legal ranges
    always_comb begin
        if (in_ch_reg == '0) begin
            n_in = CNT_W'(1);
        end else if (int'(in_ch_reg) > MAX_CHANNELS) begin
            n_in = CNT_W'(MAX_CHANNELS);
        end else begin
            n_in = in_ch_reg;
        end
        if (out_ch_reg == '0) begin
            n_out = CNT_W'(1);
        end else if (int'(out_ch_reg) > OUT_LIMIT) begin
            n_out = CNT_W'(OUT_LIMIT);
        end else begin
            n_out = out_ch_reg;
        end
    end

    assign s_tready   = !q_full;
    assign accept     = s_tvalid && s_tready;
    assign is_sample  = (op_t'(s_tuser) == OP_SAMPLE);
    assign cnt_inc    = cnt_reg + CNT_W'(1);
    // frame ends once the count reaches the channel count (or wraps)
    assign frame_done = !((cnt_inc < n_in) && (cnt_inc != '0));

    always_comb begin
        cnt_next = cnt_reg;
        if (accept && is_sample) begin
            cnt_next = frame_done ? '0 : cnt_inc;
        end
    end

    always_comb begin
        q_entry.kind        = op_t'(s_tuser);
        q_entry.row         = s_tdata[ROW_LSB +: CH_W];
        q_entry.col         = s_tdata[COL_LSB +: CH_W];
        q_entry.gain_ok     = (int'(q_entry.row) < MAX_CHANNELS) &&
                              (int'(q_entry.col) < MAX_CHANNELS);
        q_entry.coefficient = s_tdata[COEF_LSB +: COEF_W];
        q_entry.sample      = s_tdata[SAMPLE_LSB +: SAMPLE_W];
        q_entry.store_en    = (int'(cnt_reg) < MAX_CHANNELS);
        q_entry.store_idx   = cnt_reg;
        q_entry.mix         = is_sample && frame_done;
        q_entry.n_in        = n_in;
        q_entry.n_out       = n_out;
    end

    assign q_push = accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_ch_reg  <= CH_COUNT_RESET;
            out_ch_reg <= CH_COUNT_RESET;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (cfg_wr_en) begin
                unique case (cfg_reg_t'(cfg_addr))
                    REG_INPUT_CHANNELS:  in_ch_reg  <= cfg_wdata;
                    REG_OUTPUT_CHANNELS: out_ch_reg <= cfg_wdata;
                endcase
            end
        end
    end
endmodule

>>> sv/cmm_queue.sv
// Short FIFO of classified items between front and back.
module cmm_queue #(
    parameter int DEPTH = cmm_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  cmm_pkg::cmm_entry_t din,
    output logic                full,
    input  logic                pop,
    output cmm_pkg::cmm_entry_t dout,
    output logic                valid
);
    import cmm_pkg::*;

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    cmm_entry_t        slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FILL_W-1:0] fill_reg, fill_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full  = (fill_reg == FILL_W'(DEPTH));
    assign valid = (fill_reg != '0);
    assign dout  = slot_reg[rd_ptr_reg];

    always_comb begin
        unique case ({push, pop})
            2'b10:   fill_next = fill_reg + FILL_W'(1);
            2'b01:   fill_next = fill_reg - FILL_W'(1);
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            fill_reg <= fill_next;
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end
endmodule

>>> sv/cmm_back.sv
// Back end: gain table, frame store, MAC pipeline and output register.
module cmm_back #(
    parameter int MAX_CHANNELS   = cmm_pkg::MAX_CHANNELS_DEF,
    parameter int GAIN_FRAC_BITS = cmm_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  cmm_pkg::cmm_entry_t           q_entry,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cmm_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import cmm_pkg::*;

    localparam int IDX_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int G_DEPTH = MAX_CHANNELS * MAX_CHANNELS;
    localparam int AW      = (G_DEPTH > 1) ? $clog2(G_DEPTH) : 1;
    localparam int ACC_W   = PROD_W - GAIN_FRAC_BITS + IDX_W + 2;
    localparam int PAD_W   = M_TDATA_W - CH_W - SAMPLE_W;

    typedef struct packed {
        logic            first;
        logic            last;
        logic [CH_W-1:0] ch;
        logic            frame_last;
    } tag_t;

    back_state_t state_reg, state_next;

    logic [IDX_W-1:0] k_reg;
    logic [CH_W-1:0]  ch_reg;
    logic [CNT_W-1:0] n_in_reg, n_out_reg;
    logic             last_k, last_ch, issue_fire, start_mix, en;

    logic [G_DEPTH-1:0]         gvalid_reg;
    logic signed [SAMPLE_W-1:0] frame_reg [MAX_CHANNELS];

    logic          gain_we;
    logic [AW-1:0] gain_waddr, rd_addr;
    logic [COEF_W-1:0] gain_rdata;

    // pipeline stages
    logic                       s1_valid_reg, s1_gvalid_reg;
    tag_t                       s1_tag_reg, issue_tag;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    logic signed [COEF_W-1:0]   s1_gain;

    logic                       s2_valid_reg;
    tag_t                       s2_tag_reg;
    logic signed [PROD_W-1:0]   s2_prod_reg, s2_prod_next;

    logic signed [ACC_W-1:0]    acc_reg, acc_base, acc_q, acc_sum, acc_next;
    logic                       acc_rem_nz;

    logic                       r_valid_reg;
    logic signed [ACC_W-1:0]    r_sum_reg;
    logic [CH_W-1:0]            r_ch_reg;
    logic                       r_flast_reg;

    logic                       m_valid_reg, m_last_reg;
    logic [CH_W-1:0]            m_ch_reg;
    logic signed [SAMPLE_W-1:0] m_mix_reg, clip_val;

    // whole pipeline moves when the output register can take a result
    assign en = !m_valid_reg || m_tready;

    assign last_k  = ((CNT_W'(k_reg) + CNT_W'(1)) == n_in_reg);
    assign last_ch = ((CNT_W'(ch_reg) + CNT_W'(1)) == n_out_reg);

    // ---- issue sequencer ----
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid && q_entry.kind == OP_SAMPLE && q_entry.mix) begin
                    state_next = BK_ISSUE;
                end
            end
            BK_ISSUE: begin
                if (en && last_k && last_ch) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        q_pop      = 1'b0;
        issue_fire = 1'b0;
        unique case (state_reg)
            BK_IDLE:  q_pop      = q_valid;
            BK_ISSUE: issue_fire = en;
            default: begin
                q_pop      = 1'b0;
                issue_fire = 1'b0;
            end
        endcase
    end

    assign start_mix = q_pop && (q_entry.kind == OP_SAMPLE) && q_entry.mix;
    assign gain_we   = q_pop && (q_entry.kind == OP_COEF) && q_entry.gain_ok;
    assign gain_waddr = AW'(int'(q_entry.row) * MAX_CHANNELS + int'(q_entry.col));
    assign rd_addr    = AW'(int'(ch_reg) * MAX_CHANNELS + int'(k_reg));

    always_comb begin
        issue_tag.first      = (k_reg == '0);
        issue_tag.last       = last_k;
        issue_tag.ch         = ch_reg;
        issue_tag.frame_last = last_ch;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= BK_IDLE;
            k_reg      <= '0;
            ch_reg     <= '0;
            gvalid_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (gain_we) begin
                gvalid_reg[gain_waddr] <= 1'b1;
            end
            if (start_mix) begin
                k_reg  <= '0;
                ch_reg <= '0;
            end else if (issue_fire) begin
                if (last_k) begin
                    k_reg  <= '0;
                    ch_reg <= ch_reg + CH_W'(1);
                end else begin
                    k_reg <= k_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start_mix) begin
            n_in_reg  <= q_entry.n_in;
            n_out_reg <= q_entry.n_out;
        end
        if (q_pop && q_entry.kind == OP_SAMPLE && q_entry.store_en) begin
            frame_reg[q_entry.store_idx[IDX_W-1:0]] <= q_entry.sample;
        end
    end

    cmm_ram #(
        .WIDTH (COEF_W),
        .DEPTH (G_DEPTH)
    ) u_gain_ram (
        .aclk  (aclk),
        .we    (gain_we),
        .waddr (gain_waddr),
        .wdata (q_entry.coefficient),
        .re    (issue_fire),
        .raddr (rd_addr),
        .rdata (gain_rdata)
    );

    // ---- MAC pipeline ----
    // never-written gains read as zero
    assign s1_gain      = s1_gvalid_reg ? $signed(gain_rdata) : '0;
    assign s2_prod_next = s1_gain * s1_sample_reg;

    // trunc((acc*2^F + p) / 2^F) == floor part, plus one when negative with a remainder
    assign acc_base   = s2_tag_reg.first ? '0 : acc_reg;
    assign acc_q      = ACC_W'(s2_prod_reg >>> GAIN_FRAC_BITS);
    assign acc_rem_nz = |s2_prod_reg[GAIN_FRAC_BITS-1:0];
    assign acc_sum    = acc_base + acc_q;
    assign acc_next   = (acc_sum[ACC_W-1] && acc_rem_nz) ? acc_sum + ACC_W'(1) : acc_sum;

    always_comb begin
        if (r_sum_reg < ACC_W'(CLIP_LOW)) begin
            clip_val = CLIP_LOW;
        end else if (r_sum_reg > ACC_W'(CLIP_HIGH)) begin
            clip_val = CLIP_HIGH;
        end else begin
            clip_val = r_sum_reg[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            r_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= issue_fire;
            s2_valid_reg <= s1_valid_reg;
            r_valid_reg  <= s2_valid_reg && s2_tag_reg.last;
            m_valid_reg  <= r_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_tag_reg    <= issue_tag;
            s1_sample_reg <= frame_reg[k_reg];
            s1_gvalid_reg <= gvalid_reg[rd_addr];
            s2_tag_reg    <= s1_tag_reg;
            s2_prod_reg   <= s2_prod_next;
            if (s2_valid_reg) begin
                acc_reg <= acc_next;
            end
            r_sum_reg   <= acc_next;
            r_ch_reg    <= s2_tag_reg.ch;
            r_flast_reg <= s2_tag_reg.frame_last;
            m_mix_reg   <= clip_val;
            m_ch_reg    <= r_ch_reg;
            m_last_reg  <= r_flast_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, m_ch_reg, m_mix_reg};
endmodule

>>> sv/channel_matrix_mixer_top.sv
// Channel matrix mixer top level: front end, item queue and MAC back end.
// Path: the sample that completes a frame goes through the queue, the issue sequencer
//   and the s1, s2, r and m registers before output channel 0 is valid.
// Mix: the back end takes queued items in turn; for each frame it issues n_in * n_out
//   terms through its single MAC and takes no new item until the last one is issued.
// Reset: synchronous, active low; channel counts return to 2, sample count, queue,
//   gain valid bits and pipeline clear.
module channel_matrix_mixer_top #(
    parameter int MAX_CHANNELS   = cmm_pkg::MAX_CHANNELS_DEF,
    parameter int GAIN_FRAC_BITS = cmm_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // channel count registers: 0 = input_channels, 1 = output_channels
    input  logic                           cfg_wr_en,
    input  logic [cmm_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [cmm_pkg::CFG_W-1:0]      cfg_wdata,
    // input items
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata, low bit up: row_index[2:0], column_index[5:3],
    //   coefficient[23:6], sample[39:24]
    input  logic [cmm_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: operation (0 = gain write, 1 = audio sample)
    input  logic                           s_tuser,
    // mixed output items
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata, low bit up: mixed_sample[15:0], channel[18:16], zero pad[23:19]
    output logic [cmm_pkg::M_TDATA_W-1:0]  m_tdata,
    // m_tlast: last output channel of the frame
    output logic                           m_tlast
);
    import cmm_pkg::*;

    cmm_entry_t front_entry, back_entry;
    logic       q_push, q_full, q_pop, q_valid;

    // Front: decodes each item, counts samples into frames and marks the
    // sample that completes one. Never stalls unless the queue is full.
    cmm_front #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_push    (q_push),
        .q_entry   (front_entry),
        .q_full    (q_full)
    );

    // Items stay in order, so gain writes and samples land only after
    // the mix before them has read what it needs.
    cmm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (front_entry),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (back_entry),
        .valid   (q_valid)
    );

    // Back: applies gain writes and sample stores, then runs the mix one term per cycle,
    // while the output is not stalled, through RAM read, multiply, accumulate, clip.
    cmm_back #(
        .MAX_CHANNELS   (MAX_CHANNELS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (back_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );
endmodule

>>> sv/cmm_checker.sv
// Port-level assertions for the channel matrix mixer, bound to the top level.
module cmm_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [cmm_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tlast
);
    import cmm_pkg::*;

    logic [CH_W-1:0] exp_ch_reg, exp_ch_next, out_ch;

    assign out_ch = m_tdata[CH_LSB +: CH_W];

    always_comb begin
        exp_ch_next = exp_ch_reg;
        if (m_tvalid && m_tready) begin
            exp_ch_next = m_tlast ? '0 : out_ch + CH_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_ch_reg <= '0;
        end else begin
            exp_ch_reg <= exp_ch_next;
        end
    end

    // reset empties the output and the queue
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("outputs not cleared by reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output item changed");

    // channels of a frame come out in order, starting at zero
    a_ch_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_ch == exp_ch_reg)
        else $error("output channel out of sequence");

    // the highest channel always closes its frame
    a_top_ch_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_ch == CH_W'(OUT_CHANNELS_CAP - 1) |-> m_tlast)
        else $error("top channel without frame end");
endmodule

bind channel_matrix_mixer_top cmm_checker u_cmm_checker (.*);

>>> tb/tb.sv
// Self-checking testbench for the channel matrix mixer: table-driven, then random phases.
`timescale 1ns / 100ps

module tb;
    import cmm_pkg::*;

    // Run shape
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 16;
    // Idle cycles after the last expected sample before a count write or the end.
    // Covers queued gain writes and partial frames still in the pipe.
    localparam int SETTLE_CYCLES  = 100;
    // Worst quiet stretch is a full 8x8 MAC pass plus stalls; keep a wide margin
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int REPORT_LIMIT   = 10;
    localparam int PLAN_LEN       = 28;

    // One mixed output sample as seen on m_tdata / m_tlast
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mixed;
        logic [CH_W-1:0]            channel;
        logic                       last;
    } mix_result_t;

    // One row of the directed table: either a count write or an input item.
    // Typed rows carry the expected mix of output channels 0 and 1 (two outputs).
    typedef struct packed {
        logic                       is_cfg;
        logic [CFG_W-1:0]           in_val;
        logic [CFG_W-1:0]           out_val;
        op_t                        op;
        logic [CH_W-1:0]            row;
        logic [CH_W-1:0]            col;
        logic [COEF_W-1:0]          coef;
        logic [SAMPLE_W-1:0]        sample;
        logic                       typed;
        logic signed [SAMPLE_W-1:0] want0;
        logic signed [SAMPLE_W-1:0] want1;
    } plan_row_t;

    // DUT signals; every input starts at a known value
    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = REG_INPUT_CHANNELS;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // row[2:0], col[5:3], coef[23:6], sample[39:24]
    logic                  s_tuser   = OP_COEF;  // operation
    logic                  m_tvalid;
    logic                  m_tready  = 1'b1;
    logic [M_TDATA_W-1:0]  m_tdata;          // mixed_sample[15:0], channel[18:16], pad
    logic                  m_tlast;          // last output channel of the frame

    // Mirror of the block state used for prediction
    logic signed [COEF_W-1:0]   gain_mirror  [MAX_CHANNELS_DEF][MAX_CHANNELS_DEF];
    logic signed [SAMPLE_W-1:0] frame_mirror [MAX_CHANNELS_DEF];
    logic [CNT_W-1:0]           collected;
    logic [CFG_W-1:0]           in_count;
    logic [CFG_W-1:0]           out_count;

    mix_result_t frame_mix[$];     // results of the item just predicted
    mix_result_t pending_mix[$];   // expected output samples, oldest first

    // Bookkeeping
    int  errors        = 0;
    int  items_sent    = 0;
    int  gain_writes   = 0;
    int  mixes_checked = 0;
    int  count_writes  = 0;
    int  quiet_cycles  = 0;
    int  stall_left    = 0;
    bit  calm          = 1'b0;   // no idling on either side when set

    channel_matrix_mixer_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Directed table. Gains are all zero after reset, counts are 2 in / 2 out.
    plan_row_t plan [PLAN_LEN] = '{
        // reset gains: any frame mixes to zero
        '{1'b0, 4'd0, 4'd0, OP_SAMPLE, 3'd7, 3'd7, 18'h3ffff, 16'h7fff, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 4'd0, 4'd0, OP_SAMPLE, 3'd0, 3'd0, 18'h00000, 16'h8000, 1'b1, 16'sd0, 16'sd0},
        // extreme gains on column 0: just under +8.0 on row 0, -8.0 on row 1 (sample field ignored)
        '{1'b0, 4'd0, 4'd0, OP_COEF,   3'd0, 3'd0, 18'h1ffff, 16'hffff, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 4'd0, 4'd0, OP_COEF,   3'd1, 3'd0, 18'h20000, 16'h0000, 1'b0, 16'sd0, 16'sd0},
        // full-scale samples drive both rows into opposite clip limits
        '{1'b0, 4'd0, 4'd0, OP_SAMPLE, 3'd0, 3'd0, 18'h00000, 16'h7fff, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 4'd0, 4'd0, OP_SAMPLE, 3'd5, 3'd2, 18'h15555, 16'h0000, 1'b1,
          16'sh7fff, 16'sh8000},
        '{1'b0, 4'd0, 4'd0, OP_SAMPLE, 3'd0, 3'd0, 18'h00000, 16'h8000, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 4'd0, 4'd0, OP_SAMPLE, 3'd0, 3'd0, 18'h00000, 16'h0000, 1'b1,
          16'sh8000, 16'sh7fff},
        // unity on row 0 col 1, smallest negative gain on row 1 col 1
        '{1'b0, 4'd0, 4'd0, OP_COEF,   3'd0, 3'd1, 18'h04000, 16'h1234, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 4'd0, 4'd0, OP_COEF,   3'd1, 3'd1, 18'h3ffff, 16'h0000, 1'b0, 16'sd0, 16'sd0},
        // tiny samples: per-term truncation toward zero
        '{1'b0, 4'd0, 4'd0, OP_SAMPLE, 3'd0, 3'd0, 18'h00000, 16'h0001, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 4'd0, 4'd0, OP_SAMPLE, 3'd0, 3'd0, 18'h00000, 16'h0001, 1'b0, 16'sd0, 16'sd0},
        // top corner of the matrix
        '{1'b0, 4'd0, 4'd0, OP_COEF,   3'd7, 3'd7, 18'h1ffff, 16'h5a5a, 1'b0, 16'sd0, 16'sd0},
        // full 8x8 frame
        '{1'b1, 4'd8, 4'd8, OP_COEF,   3'd0, 3'd0, 18'h00000, 16'h0000, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 4'd0, 4'd0, OP_SAMPLE, 3'd0, 3'd0, 18'h00000, 16'h0100, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 4'd0, 4'd0, OP_SAMPLE, 3'd0, 3'd0, 18'h00000, 16'hff00, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 4'd0, 4'd0, OP_SAMPLE, 3'd0, 3'd0, 18'h00000, 16'h7fff, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 4'd0, 4'd0, OP_SAMPLE, 3'd0, 3'd0, 18'h00000, 16'h8000, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 4'd0, 4'd0, OP_SAMPLE, 3'd0, 3'd0, 18'h00000, 16'h0001, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 4'd0, 4'd0, OP_SAMPLE, 3'd0, 3'd0, 18'h00000, 16'hffff, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 4'd0, 4'd0, OP_SAMPLE, 3'd0, 3'd0, 18'h00000, 16'h1234, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 4'd0, 4'd0, OP_SAMPLE, 3'd0, 3'd0, 18'h00000, 16'h4000, 1'b0, 16'sd0, 16'sd0},
        // zero counts saturate to one in / one out
        '{1'b1, 4'd0, 4'd0, OP_COEF,   3'd0, 3'd0, 18'h00000, 16'h0000, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 4'd0, 4'd0, OP_SAMPLE, 3'd0, 3'd0, 18'h00000, 16'h1234, 1'b0, 16'sd0, 16'sd0},
        // oversized counts saturate to eight; then shrink the frame mid-way
        '{1'b1, 4'd15, 4'd15, OP_COEF, 3'd0, 3'd0, 18'h00000, 16'h0000, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 4'd0, 4'd0, OP_SAMPLE, 3'd0, 3'd0, 18'h00000, 16'h0005, 1'b0, 16'sd0, 16'sd0},
        '{1'b1, 4'd1, 4'd15, OP_COEF,  3'd0, 3'd0, 18'h00000, 16'h0000, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, 4'd0, 4'd0, OP_SAMPLE, 3'd0, 3'd0, 18'h00000, 16'hfff9, 1'b0, 16'sd0, 16'sd0}
    };

    // Predict the effect of one accepted item; fills frame_mix with its outputs.
    function automatic void predict_mix(op_t op, logic [CH_W-1:0] row, logic [CH_W-1:0] col,
                                        logic [COEF_W-1:0] coef, logic [SAMPLE_W-1:0] sample);
        int          n_in;
        int          n_out;
        int          out_cap;
        longint      acc;
        longint      scale;
        mix_result_t r;

        frame_mix.delete();
        if (op == OP_COEF) begin
            // 3-bit indexes can never leave the 8x8 table
            gain_mirror[row][col] = $signed(coef);
            return;
        end

        out_cap = (MAX_CHANNELS_DEF < OUT_CHANNELS_CAP) ? MAX_CHANNELS_DEF : OUT_CHANNELS_CAP;
        n_in  = (in_count == 0) ? 1 : (in_count > MAX_CHANNELS_DEF) ? MAX_CHANNELS_DEF
                                                                    : int'(in_count);
        n_out = (out_count == 0) ? 1 : (out_count > out_cap) ? out_cap : int'(out_count);

        if (collected < MAX_CHANNELS_DEF)
            frame_mirror[collected] = $signed(sample);
        collected = collected + 1'b1;
        // frame closes once the count reaches the current input width
        if (collected < n_in && collected != 0)
            return;
        collected = '0;

        scale = longint'(1) << GAIN_FRAC_BITS_DEF;
        for (int ch = 0; ch < n_out; ch++) begin
            acc = 0;
            for (int k = 0; k < n_in; k++)
                acc = (acc * scale + longint'(gain_mirror[ch][k]) * longint'(frame_mirror[k]))
                      / scale;   // truncates toward zero after every term
            if (acc < longint'(CLIP_LOW))
                acc = longint'(CLIP_LOW);
            if (acc > longint'(CLIP_HIGH))
                acc = longint'(CLIP_HIGH);
            r.mixed   = SAMPLE_W'(acc);
            r.channel = CH_W'(ch);
            r.last    = (ch + 1 == n_out);
            frame_mix.push_back(r);
        end
    endfunction

    // Present one item, hold it until accepted, then record what it should produce.
    // s_tvalid stays high on return so back-to-back items need no second assignment.
    task automatic send_item(op_t op, logic [CH_W-1:0] row, logic [CH_W-1:0] col,
                             logic [COEF_W-1:0] coef, logic [SAMPLE_W-1:0] sample,
                             logic typed, logic signed [SAMPLE_W-1:0] want0,
                             logic signed [SAMPLE_W-1:0] want1);
        int          gap;
        mix_result_t r;

        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {sample, coef, col, row};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);

        items_sent++;
        if (op == OP_COEF)
            gain_writes++;
        predict_mix(op, row, col, coef, sample);
        if (typed) begin
            // known answer for a two-output frame
            r = '{want0, CH_W'(0), 1'b0};
            pending_mix.push_back(r);
            r = '{want1, CH_W'(1), 1'b1};
            pending_mix.push_back(r);
        end else begin
            foreach (frame_mix[i])
                pending_mix.push_back(frame_mix[i]);
        end
    endtask

    // Stop the input, wait for every expected sample, then let the pipe empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_mix.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write both channel counts; only called with the block idle.
    task automatic write_counts(logic [CFG_W-1:0] in_val, logic [CFG_W-1:0] out_val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_INPUT_CHANNELS;
        cfg_wdata <= in_val;
        @(posedge aclk);
        cfg_addr  <= REG_OUTPUT_CHANNELS;
        cfg_wdata <= out_val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        in_count  = in_val;
        out_count = out_val;
        count_writes++;
    endtask

    // Output-side back-pressure: random stall bursts
    always @(posedge aclk) begin
        if (!aresetn || calm) begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 9) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 11);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each accepted output sample against the oldest expectation
    always @(posedge aclk) begin : check_mix
        mix_result_t want;
        mix_result_t got;

        if (aresetn && m_tvalid && m_tready) begin
            got.mixed   = m_tdata[MIX_LSB +: SAMPLE_W];
            got.channel = m_tdata[CH_LSB +: CH_W];
            got.last    = m_tlast;
            if (pending_mix.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("ERROR %0t: unexpected output mix=%0d ch=%0d last=%0b",
                             $realtime, got.mixed, got.channel, got.last);
            end else begin
                want = pending_mix.pop_front();
                mixes_checked++;
                if (got.mixed !== want.mixed || got.channel !== want.channel
                        || got.last !== want.last) begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("ERROR %0t: mix exp %0d ch %0d last %0b, got %0d ch %0d last %0b",
                                 $realtime, want.mixed, want.channel, want.last,
                                 got.mixed, got.channel, got.last);
                end
            end
        end
    end

    // Watchdog: too long without any item moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no item moved for %0d cycles, %0d samples still expected",
                     quiet_cycles, pending_mix.size());
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main sequence
    initial begin : stimulus
        logic [CFG_W-1:0]    phase_in  [PHASES];
        logic [CFG_W-1:0]    phase_out [PHASES];
        logic [CFG_W-1:0]    in_val;
        logic [CFG_W-1:0]    out_val;
        logic [COEF_W-1:0]   coef;
        logic [SAMPLE_W-1:0] smp;

        // count settings per random phase; phase 4 is drawn at random
        phase_in  = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd8};
        phase_out = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd5, 4'd8};

        // predictor starts from reset state; its frame entries are zero until written
        foreach (gain_mirror[r, c])
            gain_mirror[r][c] = '0;
        foreach (frame_mirror[k])
            frame_mirror[k] = '0;
        collected = '0;
        in_count  = CH_COUNT_RESET;
        out_count = CH_COUNT_RESET;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table
        for (int p = 0; p < PLAN_LEN; p++) begin
            if (plan[p].is_cfg) begin
                settle();
                write_counts(plan[p].in_val, plan[p].out_val);
            end else begin
                send_item(plan[p].op, plan[p].row, plan[p].col, plan[p].coef,
                          plan[p].sample, plan[p].typed, plan[p].want0, plan[p].want1);
            end
        end

        // Random phases: new counts, then a mix of gain writes and samples.
        // Partial frames left at a phase edge carry over into the new counts.
        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            // one quiet stretch mid-run, and one at the tail
            calm = (phase == 2 || phase == PHASES - 1);
            in_val  = (phase == 4) ? CFG_W'($urandom_range(0, 15)) : phase_in[phase];
            out_val = (phase == 4) ? CFG_W'($urandom_range(0, 15)) : phase_out[phase];
            write_counts(in_val, out_val);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 9) < 3) begin
                    case ($urandom_range(0, 7))
                        0:       coef = 18'h1ffff;
                        1:       coef = 18'h20000;
                        2, 3:    coef = COEF_W'($urandom);
                        // half the gains fall within +/-1.0 so mixes don't all clip
                        default: coef = COEF_W'(int'($urandom_range(0, 32768)) - 16384);
                    endcase
                    send_item(OP_COEF, CH_W'($urandom), CH_W'($urandom), coef,
                              SAMPLE_W'($urandom), 1'b0, '0, '0);
                end else begin
                    case ($urandom_range(0, 7))
                        0:       smp = 16'h7fff;
                        1:       smp = 16'h8000;
                        default: smp = SAMPLE_W'($urandom);
                    endcase
                    send_item(OP_SAMPLE, CH_W'($urandom), CH_W'($urandom),
                              COEF_W'($urandom), smp, 1'b0, '0, '0);
                end
            end
        end

        settle();
        $display("Run covered %0d items (%0d gain writes) and %0d checked output samples",
                 items_sent, gain_writes, mixes_checked);
        $display("over %0d channel-count settings, %0d mismatches", count_writes, errors);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/cmm_pkg.sv
sv/cmm_ram.sv
sv/cmm_front.sv
sv/cmm_queue.sv
sv/cmm_back.sv
sv/channel_matrix_mixer_top.sv
sv/cmm_checker.sv
tb/tb.sv
